### src/gb5_pkg.sv
package gb5_pkg;

    localparam int PIX_W          = 8;
    localparam int POS_W          = 11;
    localparam int DIM_W          = 12;
    localparam int COEF_W         = 16;
    localparam int FRAC_W         = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int KSIZE          = 5;
    localparam int STORE_ROWS     = 4;
    localparam int NUM_COEF       = 6;
    localparam int MIN_DIM        = 5;
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    // group sum of up to eight pixels, product with a coefficient, sums of products
    localparam int GRP_W  = PIX_W + 3;
    localparam int PROD_W = GRP_W + COEF_W;
    localparam int PSUM_W = PROD_W + 1;
    localparam int ACC_W  = PSUM_W + 2;

    localparam logic [DIM_W-1:0]  WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0]  HEIGHT_RST = DIM_W'(480);

    // coefficient slots, ordered by sorted offset pair
    localparam int C_D0_0 = 0;
    localparam int C_D0_1 = 1;
    localparam int C_D1_1 = 2;
    localparam int C_D0_2 = 3;
    localparam int C_D1_2 = 4;
    localparam int C_D2_2 = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_COEF_D0_0    = 3'd2,
        REG_COEF_D0_1    = 3'd3,
        REG_COEF_D1_1    = 3'd4,
        REG_COEF_D0_2    = 3'd5,
        REG_COEF_D1_2    = 3'd6,
        REG_COEF_D2_2    = 3'd7
    } cfg_reg_e;

    typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] window_t;
    typedef logic [NUM_COEF-1:0][COEF_W-1:0]         coef_set_t;

    typedef struct packed {
        logic             interior;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } out_pos_t;

    localparam coef_set_t COEF_RST = {
        16'd2081, 16'd2459, 16'd2599, 16'd2904, 16'd3070, 16'd3246
    };

endpackage

### src/gb5_ram.sv
module gb5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/gb5_front.sv
module gb5_front import gb5_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [PIX_W-1:0] pixel_in,
    input  logic             frame_start,
    input  logic [DIM_W-1:0] width_cfg,
    input  logic [DIM_W-1:0] height_cfg,
    output logic             win_valid,
    output window_t          win,
    output out_pos_t         win_pos,
    input  logic             win_stall
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int WC     = (WW > DIM_W) ? WW : DIM_W;
    localparam int HC     = (HW > DIM_W) ? HW : DIM_W;
    localparam int WORD_W = STORE_ROWS * PIX_W;

    logic [WC-1:0] wx;
    logic [HC-1:0] hx;
    logic [WW-1:0] w;
    logic [HW-1:0] h;

    logic [CW-1:0] col_count_reg, col_count_next;
    logic [RW-1:0] row_count_reg, row_count_next;
    logic [WW-1:0] c0, cn;
    logic [HW-1:0] r0, r1, rn;
    logic [CW-1:0] col_acc;
    logic [RW-1:0] row_acc;

    logic             s1_valid_reg, s2_valid_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [RW-1:0]    s1_row_reg;
    logic [PIX_W-1:0] s1_px_reg;
    logic             en1, en2, accept, s1_move;

    logic [WORD_W-1:0] ram_rdata, rd_word, wr_word, byp_word_reg;
    logic              byp_reg;
    logic [KSIZE-1:0][PIX_W-1:0] new_col;

    window_t  win_reg;
    out_pos_t pos_reg, pos_next;

    logic [WW-1:0] col_x, oc;
    logic [HW-1:0] row_x, orow, rneed;
    logic          near, wrapped;

    // size clamp
    always_comb
    begin
        wx = WC'(width_cfg);
        hx = HC'(height_cfg);
        if (wx < WC'(MIN_DIM))
            w = WW'(MIN_DIM);
        else if (wx > WC'(MAX_WIDTH))
            w = WW'(MAX_WIDTH);
        else
            w = WW'(wx);
        if (hx < HC'(MIN_DIM))
            h = HW'(MIN_DIM);
        else if (hx > HC'(MAX_HEIGHT))
            h = HW'(MAX_HEIGHT);
        else
            h = HW'(hx);
    end

    assign en2      = !s2_valid_reg || !win_stall;
    assign en1      = !s1_valid_reg || en2;
    assign in_stall = !en1;
    assign accept   = in_valid && en1;
    assign s1_move  = s1_valid_reg && en2;

    // position of the incoming item and of the next one
    always_comb
    begin
        c0 = frame_start ? '0 : WW'(col_count_reg);
        r0 = frame_start ? '0 : HW'(row_count_reg);
        r1 = r0;
        if (c0 >= w)
        begin
            c0 = '0;
            r1 = r0 + HW'(1);
        end
        if (r1 >= h)
        begin
            r1 = '0;
        end
        col_acc = CW'(c0);
        row_acc = RW'(r1);

        cn = WW'(col_acc) + WW'(1);
        rn = HW'(row_acc) + HW'(1);
        if (cn >= w)
        begin
            col_count_next = '0;
            row_count_next = (rn >= h) ? '0 : RW'(rn);
        end
        else
        begin
            col_count_next = CW'(cn);
            row_count_next = row_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            byp_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
                byp_reg       <= s1_move && (s1_col_reg == col_acc);
            end
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg   <= col_acc;
            s1_row_reg   <= row_acc;
            s1_px_reg    <= pixel_in;
            byp_word_reg <= wr_word;
        end
    end

    // one word per column: byte s holds the row with row mod 4 == s
    gb5_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_move),
        .waddr (s1_col_reg),
        .wdata (wr_word),
        .re    (accept),
        .raddr (col_acc),
        .rdata (ram_rdata)
    );

    // same column written back at the edge it was read
    assign rd_word = byp_reg ? byp_word_reg : ram_rdata;

    always_comb
    begin
        wr_word = rd_word;
        wr_word[s1_row_reg[1:0] * PIX_W +: PIX_W] = s1_px_reg;
        for (int r = 0; r < STORE_ROWS; r++)
        begin
            new_col[r] = rd_word[2'(s1_row_reg[1:0] + 2'(r)) * PIX_W +: PIX_W];
        end
        new_col[KSIZE-1] = s1_px_reg;
    end

    // result position: two rows and two pixels back
    always_comb
    begin
        col_x   = WW'(s1_col_reg);
        row_x   = HW'(s1_row_reg);
        near    = col_x < WW'(2);
        oc      = near ? (w - (WW'(2) - col_x)) : (col_x - WW'(2));
        rneed   = near ? HW'(3) : HW'(2);
        wrapped = row_x < rneed;
        orow    = wrapped ? (h - (rneed - row_x)) : (row_x - rneed);
        pos_next.interior = !wrapped && (orow >= HW'(2)) && (orow < h - HW'(2))
                            && (oc >= WW'(2)) && (oc < w - WW'(2));
        pos_next.row = POS_W'(orow);
        pos_next.col = POS_W'(oc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (s1_move)
        begin
            for (int r = 0; r < KSIZE; r++)
            begin
                for (int c = 0; c < KSIZE - 1; c++)
                begin
                    win_reg[r][c] <= win_reg[r][c+1];
                end
                win_reg[r][KSIZE-1] <= new_col[r];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            pos_reg <= pos_next;
        end
    end

    assign win_valid = s2_valid_reg;
    assign win       = win_reg;
    assign win_pos   = pos_reg;

endmodule

### src/gb5_mac.sv
module gb5_mac import gb5_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             win_valid,
    output logic             win_stall,
    input  window_t          win,
    input  out_pos_t         win_pos,
    input  coef_set_t        coef,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [PIX_W-1:0] pixel_out,
    output logic [POS_W-1:0] out_row,
    output logic [POS_W-1:0] out_col
);

    localparam int SH_W = ACC_W - FRAC_W;

    logic v3_reg, v4_reg, v5_reg, vo_reg;
    logic en3, en4, en5, en_o;

    out_pos_t pos3_reg, pos4_reg, pos5_reg, poso_reg;

    logic [GRP_W-1:0]  grp_next [NUM_COEF];
    logic [GRP_W-1:0]  grp_reg  [NUM_COEF];
    logic [PROD_W-1:0] prod_reg [NUM_COEF];
    logic [PSUM_W-1:0] psum_reg [3];
    logic [ACC_W-1:0]  acc;
    logic [SH_W-1:0]   shifted;
    logic [PIX_W-1:0]  sat, pix_reg;

    assign en_o      = !vo_reg || !out_stall;
    assign en5       = !v5_reg || en_o;
    assign en4       = !v4_reg || en5;
    assign en3       = !v3_reg || en4;
    assign win_stall = !en3;

    // symmetric taps share a coefficient: add pixels first
    always_comb
    begin
        grp_next[C_D0_0] = GRP_W'(win[2][2]);
        grp_next[C_D0_1] = GRP_W'(win[1][2]) + GRP_W'(win[3][2])
                         + GRP_W'(win[2][1]) + GRP_W'(win[2][3]);
        grp_next[C_D1_1] = GRP_W'(win[1][1]) + GRP_W'(win[1][3])
                         + GRP_W'(win[3][1]) + GRP_W'(win[3][3]);
        grp_next[C_D0_2] = GRP_W'(win[0][2]) + GRP_W'(win[4][2])
                         + GRP_W'(win[2][0]) + GRP_W'(win[2][4]);
        grp_next[C_D1_2] = GRP_W'(win[0][1]) + GRP_W'(win[0][3])
                         + GRP_W'(win[4][1]) + GRP_W'(win[4][3])
                         + GRP_W'(win[1][0]) + GRP_W'(win[3][0])
                         + GRP_W'(win[1][4]) + GRP_W'(win[3][4]);
        grp_next[C_D2_2] = GRP_W'(win[0][0]) + GRP_W'(win[0][4])
                         + GRP_W'(win[4][0]) + GRP_W'(win[4][4]);
    end

    always_comb
    begin
        acc     = ACC_W'(psum_reg[0]) + ACC_W'(psum_reg[1]) + ACC_W'(psum_reg[2]);
        shifted = acc[ACC_W-1:FRAC_W];
        sat     = (|shifted[SH_W-1:PIX_W]) ? {PIX_W{1'b1}} : shifted[PIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en3)
                v3_reg <= win_valid;
            if (en4)
                v4_reg <= v3_reg;
            if (en5)
                v5_reg <= v4_reg;
            if (en_o)
                vo_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && win_valid)
        begin
            pos3_reg <= win_pos;
            for (int i = 0; i < NUM_COEF; i++)
                grp_reg[i] <= grp_next[i];
        end
        if (en4 && v3_reg)
        begin
            pos4_reg <= pos3_reg;
            for (int i = 0; i < NUM_COEF; i++)
                prod_reg[i] <= PROD_W'(grp_reg[i]) * PROD_W'(coef[i]);
        end
        if (en5 && v4_reg)
        begin
            pos5_reg <= pos4_reg;
            for (int i = 0; i < 3; i++)
                psum_reg[i] <= PSUM_W'(prod_reg[2*i]) + PSUM_W'(prod_reg[2*i+1]);
        end
        if (en_o && v5_reg)
        begin
            poso_reg <= pos5_reg;
            pix_reg  <= pos5_reg.interior ? sat : '0;
        end
    end

    assign out_valid = vo_reg;
    assign pixel_out = pix_reg;
    assign out_row   = poso_reg.row;
    assign out_col   = poso_reg.col;

endmodule

### src/gaussian_blur_5x5.sv
// 5x5 Gaussian blur, 8-bit grayscale, raster-order stream.
// Input channel: in_valid/in_stall with pixel_in and frame_start (first pixel of
// a frame). Output channel: out_valid/out_stall with pixel_out, out_row, out_col.
// Each input item yields one output item for the pixel two rows and two
// columns back; the first 2*width+2 items of a frame report the previous
// frame's tail positions with value zero, as do all pixels within two of an edge.
// An accepted item passes the stage-1, window, group-sum, product, partial-sum
// and output registers. Throughput: one item per clock unless out_stall holds;
// each item does one read and one write of the line-store word for its column,
// with a bypass when the same column is read at the edge it is written back.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index selects width,
// height or one of six Q0.16 coefficients; write only while the block is idle.
// Reset clears counters, window and pipeline valids and loads default config.
// A stalled output holds its item; the pipeline fills its empty stages and then
// stalls the input. The line store needs no clearing after reset.
module gaussian_blur_5x5 import gb5_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel_in,
    input  logic                  frame_start,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIX_W-1:0]      pixel_out,
    output logic [POS_W-1:0]      out_row,
    output logic [POS_W-1:0]      out_col
);

    logic [DIM_W-1:0] width_reg, height_reg;
    coef_set_t        coef_reg;

    logic     win_valid, win_stall;
    window_t  win;
    out_pos_t win_pos;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            coef_reg   <= COEF_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_IMAGE_WIDTH:  width_reg        <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg       <= cfg_data[DIM_W-1:0];
                REG_COEF_D0_0:    coef_reg[C_D0_0] <= cfg_data;
                REG_COEF_D0_1:    coef_reg[C_D0_1] <= cfg_data;
                REG_COEF_D1_1:    coef_reg[C_D1_1] <= cfg_data;
                REG_COEF_D0_2:    coef_reg[C_D0_2] <= cfg_data;
                REG_COEF_D1_2:    coef_reg[C_D1_2] <= cfg_data;
                REG_COEF_D2_2:    coef_reg[C_D2_2] <= cfg_data;
            endcase
        end
    end

    gb5_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_in    (pixel_in),
        .frame_start (frame_start),
        .width_cfg   (width_reg),
        .height_cfg  (height_reg),
        .win_valid   (win_valid),
        .win         (win),
        .win_pos     (win_pos),
        .win_stall   (win_stall)
    );

    gb5_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_valid (win_valid),
        .win_stall (win_stall),
        .win       (win),
        .win_pos   (win_pos),
        .coef      (coef_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_out (pixel_out),
        .out_row   (out_row),
        .out_col   (out_col)
    );

endmodule
